[design/smcs_pkg.sv]
// ----------------------------------------------------------------------------
// smcs_pkg
// Shared types, field widths and command codes of the sparse Markov chain
// stepper.
// ----------------------------------------------------------------------------
package smcs_pkg;

  localparam int STATE_W         = 6;
  localparam int SLOT_W          = 8;
  localparam int PROB_W          = 20;
  localparam int COUNT_W         = 32;
  localparam int LIM_W           = 7;
  localparam int ENT_CNT_W       = 9;
  localparam int CFG_DATA_W      = 9;
  // 511 entries of up to 2^20-1 each stay below 2^29
  localparam int SUM_W           = 29;
  localparam int DEF_MAX_STATES  = 64;
  localparam int DEF_MAX_ENTRIES = 256;
  localparam int STATES_RESET    = 64;

  typedef logic [STATE_W-1:0] state_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_STATES_IN_USE  = 1'd0,
    REG_ENTRIES_IN_USE = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                command;
    logic [SLOT_W-1:0]   slot;
    state_t              source_state;
    state_t              dest_state;
    logic [PROB_W-1:0]   probability;
    logic [PROB_W-1:0]   random_value;
    state_t              target_state;
  } in_item_t;

  typedef struct packed {
    state_t              present_state;
    logic [COUNT_W-1:0]  visit_count;
    logic                moved;
  } out_item_t;

  typedef struct packed {
    state_t              source;
    state_t              dest;
    logic [PROB_W-1:0]   prob;
  } entry_t;

  typedef struct packed {
    state_t              state;
    logic [PROB_W-1:0]   rnd;
    logic [LIM_W-1:0]    lim;
  } walk_req_t;

  typedef struct packed {
    logic                done;
    logic                hit;
    state_t              dest;
  } walk_res_t;

endpackage

[design/smcs_entry_mem.sv]
// ----------------------------------------------------------------------------
// smcs_entry_mem
// Transition entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smcs_entry_mem
  import smcs_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ENTRIES,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/smcs_hist_mem.sv]
// ----------------------------------------------------------------------------
// smcs_hist_mem
// Visit histogram store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smcs_hist_mem
  import smcs_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_STATES,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/smcs_walker.sv]
// ----------------------------------------------------------------------------
// smcs_walker
// Entry walk unit: streams entries out of the entry store one per cycle,
// keeps the running probability sum and stops at the first hit or when the entries run out.
// ----------------------------------------------------------------------------
module smcs_walker
  import smcs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int EW          = 8,
  parameter int CW          = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  walk_req_t     req,
  input  logic [CW-1:0] count,
  output logic [EW-1:0] mem_raddr,
  input  entry_t        mem_rdata,
  output walk_res_t     res
);

  logic             busy;
  logic             pending;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    count_q;
  logic [SUM_W-1:0] sum;
  walk_req_t        req_q;

  logic             qual;
  logic             hit;
  logic             issue;
  logic             exhausted;
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    qual      = pending && (mem_rdata.source == req_q.state) &&
                ({1'b0, mem_rdata.dest} < req_q.lim);
    sum_next  = sum + (qual ? SUM_W'(mem_rdata.prob) : '0);
    hit       = busy && qual && (sum_next != '0) && (SUM_W'(req_q.rnd) < sum_next);
    issue     = busy && !hit && (rd_idx < count_q);
    exhausted = busy && !pending && (rd_idx == count_q);
    mem_raddr = rd_idx[EW-1:0];
    res.done  = hit || exhausted;
    res.hit   = hit;
    res.dest  = mem_rdata.dest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pending <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      pending <= 1'b0;
      rd_idx  <= '0;
      sum     <= '0;
      req_q   <= req;
      count_q <= count;
    end else if (busy) begin
      if (res.done) begin
        busy    <= 1'b0;
        pending <= 1'b0;
      end else begin
        sum     <= sum_next;
        pending <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CW'(1);
        end
      end
    end
  end

endmodule

[design/sparse_markov_chain_stepper.sv]
// ----------------------------------------------------------------------------
// sparse_markov_chain_stepper
// Sparse Markov chain stepper with a loadable transition list and a
// per-state visit histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall) carry one command each: load entry,
//   step, read visit count or restart at a state. Every command yields
//   exactly one output beat (out_valid / out_stall) with the present state,
//   a visit count and the moved flag.
//   Commands run one at a time. Load, read and restart pass from acceptance
//   through S_HREAD, S_HDATA and S_OUT to a valid output beat. A step first
//   walks the effective entries_in_use entries, reading one entry per cycle
//   from the entry store, and ends early at the first chosen entry.
//   The histogram has one read and one write port; every command reads it,
//   and a step or an accepted restart writes the bumped count back.
//   The output register lets the next beat be accepted while a result still
//   waits; if the receiver stalls, the following result holds in the block
//   and in_stall stays high until the register frees up.
//   Reset starts a clearing pass over all MAX_STATES histogram entries
//   (state 0 counts one visit); in_stall is high during the pass. Config
//   writes (cfg_write / cfg_index / cfg_data) are taken at any time.
// ----------------------------------------------------------------------------
module sparse_markov_chain_stepper
  import smcs_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int HW = $clog2(MAX_STATES);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_HREAD = 6'b001000,
    S_HDATA = 6'b010000,
    S_OUT   = 6'b100000
  } fsm_t;

  fsm_t state;

  // Configuration registers
  logic [LIM_W-1:0]     states_in_use;
  logic [ENT_CNT_W-1:0] entries_in_use;

  // Chain and command context
  state_t             chain_state;
  state_t             hist_sel;
  logic               bump;
  logic               moved;
  logic [COUNT_W-1:0] res_count;
  logic [HW-1:0]      clr_addr;

  logic [LIM_W-1:0]   lim;
  logic [CW-1:0]      walk_count;
  logic               accept;
  logic               sel_ok;
  logic [COUNT_W-1:0] count_value;

  // Memory ports
  logic               ent_we;
  entry_t             ent_wdata;
  logic [EW-1:0]      ent_raddr;
  entry_t             ent_rdata;
  logic               hist_we;
  logic [HW-1:0]      hist_waddr;
  logic [COUNT_W-1:0] hist_wdata;
  logic [COUNT_W-1:0] hist_rdata;

  walk_req_t          walk_req;
  walk_res_t          walk_res;
  logic               walk_start;

  // Clamp the registers to the ranges the hardware supports
  always_comb begin
    if (states_in_use == '0) begin
      lim = LIM_W'(1);
    end else if (32'(states_in_use) > MAX_STATES) begin
      lim = LIM_W'(MAX_STATES);
    end else begin
      lim = states_in_use;
    end
    if (32'(entries_in_use) > MAX_ENTRIES) begin
      walk_count = CW'(MAX_ENTRIES);
    end else begin
      walk_count = CW'(entries_in_use);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Load writes the entry store straight from the accepted beat
  assign ent_we           = accept && (in_data.command == CMD_LOAD) &&
                            (32'(in_data.slot) < MAX_ENTRIES);
  assign ent_wdata.source = in_data.source_state;
  assign ent_wdata.dest   = in_data.dest_state;
  assign ent_wdata.prob   = in_data.probability;

  assign walk_start     = accept && (in_data.command == CMD_STEP);
  assign walk_req.state = chain_state;
  assign walk_req.rnd   = in_data.random_value;
  assign walk_req.lim   = lim;

  // Histogram count: saturating bump for visits, zero outside the store
  assign sel_ok = (32'(hist_sel) < MAX_STATES);
  always_comb begin
    if (!sel_ok) begin
      count_value = '0;
    end else if (bump && (hist_rdata != '1)) begin
      count_value = hist_rdata + COUNT_W'(1);
    end else begin
      count_value = hist_rdata;
    end
  end

  // Single histogram write port: clearing pass or write-back
  always_comb begin
    if (state == S_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr;
      hist_wdata = (clr_addr == '0) ? COUNT_W'(1) : '0;
    end else begin
      hist_we    = (state == S_HDATA) && bump && sel_ok;
      hist_waddr = HW'(hist_sel);
      hist_wdata = count_value;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use  <= LIM_W'(STATES_RESET);
      entries_in_use <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_STATES_IN_USE:  states_in_use  <= cfg_data[LIM_W-1:0];
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[ENT_CNT_W-1:0];
        default:            states_in_use  <= states_in_use;
      endcase
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      chain_state <= '0;
      out_valid   <= 1'b0;
      bump        <= 1'b0;
      moved       <= 1'b0;
    end else begin
      // Drop the output beat once the receiver takes it; a waiting result
      // reloads the register in that same cycle instead
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + HW'(1);
          if (clr_addr == HW'(MAX_STATES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            moved <= 1'b0;
            unique case (in_data.command)
              CMD_LOAD: begin
                hist_sel <= chain_state;
                bump     <= 1'b0;
                state    <= S_HREAD;
              end
              CMD_STEP: begin
                state <= S_WALK;
              end
              CMD_READ: begin
                hist_sel <= in_data.target_state;
                bump     <= 1'b0;
                state    <= S_HREAD;
              end
              CMD_RESTART: begin
                if ({1'b0, in_data.target_state} < lim) begin
                  chain_state <= in_data.target_state;
                  hist_sel    <= in_data.target_state;
                  bump        <= 1'b1;
                end else begin
                  hist_sel <= chain_state;
                  bump     <= 1'b0;
                end
                state <= S_HREAD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_WALK: begin
          if (walk_res.done) begin
            bump <= 1'b1;
            if (walk_res.hit) begin
              chain_state <= walk_res.dest;
              hist_sel    <= walk_res.dest;
              moved       <= 1'b1;
            end else begin
              hist_sel <= chain_state;
            end
            state <= S_HREAD;
          end
        end

        S_HREAD: begin
          state <= S_HDATA;
        end

        S_HDATA: begin
          res_count <= count_value;
          state     <= S_OUT;
        end

        S_OUT: begin
          // Hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.present_state <= chain_state;
            out_data.visit_count   <= res_count;
            out_data.moved         <= moved;
            state                  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  smcs_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (EW)
  ) u_entry_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (EW'(in_data.slot)),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  smcs_walker #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .EW          (EW),
    .CW          (CW)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (walk_start),
    .req       (walk_req),
    .count     (walk_count),
    .mem_raddr (ent_raddr),
    .mem_rdata (ent_rdata),
    .res       (walk_res)
  );

  smcs_hist_mem #(
    .DEPTH (MAX_STATES),
    .AW    (HW)
  ) u_hist_mem (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (HW'(hist_sel)),
    .rdata (hist_rdata)
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: sparse Markov chain stepper testbench
// Drives load, step, read and restart beats through the input channel and
// predicts every result beat with a cycle-free copy of the chain: the entry
// list, the current state and the visit histogram. Directed beats cover the
// boundary cases. Random phases then run under several register settings,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import smcs_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int ENTRY_SLOTS  = DEF_MAX_ENTRIES;
  localparam int CHAIN_STATES = DEF_MAX_STATES;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [0:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sparse_markov_chain_stepper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted chain: entry list, present state, histogram, register copies.
  state_t             tbl_src [ENTRY_SLOTS];
  state_t             tbl_dst [ENTRY_SLOTS];
  logic [PROB_W-1:0]  tbl_prob [ENTRY_SLOTS];
  state_t             cur_state;
  logic [COUNT_W-1:0] visits [CHAIN_STATES];
  logic [LIM_W-1:0]   reg_states;
  logic [ENT_CNT_W-1:0] reg_entries;

  in_item_t  command_backlog [$];
  out_item_t awaited_results [$];
  int        queued_total   = 0;
  int        accepted_total = 0;
  int        mismatches     = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  bit        hold_armed     = 1'b0;
  bit        hold_started;
  int        hold_left;
  int        cycle_count    = 0;
  out_item_t want;

  function automatic void count_visit(state_t s);
    if (visits[s] != '1) visits[s] = visits[s] + 1'b1;
  endfunction

  // Apply one command beat to the predicted chain and return its result.
  function automatic out_item_t advance_chain(in_item_t beat);
    out_item_t          r;
    int                 walk_len;
    int                 lim;
    longint unsigned    acc;
    bit                 picked;
    r = '0;
    walk_len = (reg_entries > ENTRY_SLOTS) ? ENTRY_SLOTS : int'(reg_entries);
    lim = (reg_states < 1) ? 1 : (reg_states > CHAIN_STATES) ? CHAIN_STATES
                                                             : int'(reg_states);
    case (beat.command)
      CMD_LOAD: begin
        tbl_src[beat.slot]  = beat.source_state;
        tbl_dst[beat.slot]  = beat.dest_state;
        tbl_prob[beat.slot] = beat.probability;
        r.visit_count = visits[cur_state];
      end
      CMD_STEP: begin
        acc = 0;
        picked = 1'b0;
        // first entry whose running sum exceeds the draw wins
        for (int i = 0; i < walk_len && !picked; i++) begin
          if (tbl_src[i] == cur_state && tbl_dst[i] < lim) begin
            acc += tbl_prob[i];
            if (acc != 0 && beat.random_value < acc) begin
              cur_state = tbl_dst[i];
              picked = 1'b1;
            end
          end
        end
        count_visit(cur_state);
        r.visit_count = visits[cur_state];
        r.moved = picked;
      end
      CMD_READ: begin
        r.visit_count = visits[beat.target_state];
      end
      default: begin
        // drop a restart outside the states in use
        if (beat.target_state < lim) begin
          cur_state = beat.target_state;
          count_visit(cur_state);
        end
        r.visit_count = visits[cur_state];
      end
    endcase
    r.present_state = cur_state;
    return r;
  endfunction

  function automatic in_item_t make_beat(cmd_e cmd, logic [SLOT_W-1:0] slot,
                                         state_t src, state_t dst,
                                         logic [PROB_W-1:0] prob,
                                         logic [PROB_W-1:0] rnd, state_t target);
    in_item_t b;
    b.command      = cmd;
    b.slot         = slot;
    b.source_state = src;
    b.dest_state   = dst;
    b.probability  = prob;
    b.random_value = rnd;
    b.target_state = target;
    return b;
  endfunction

  // Pick a state, mostly among the first span states so that steps find
  // entries to sum; now and then anywhere in the field.
  function automatic state_t near_state(int span);
    return ($urandom_range(0, 99) < 85) ? state_t'($urandom_range(0, span - 1))
                                        : state_t'($urandom_range(0, CHAIN_STATES - 1));
  endfunction

  function automatic in_item_t shuffle_command(int span);
    in_item_t b;
    int       pick;
    b.slot         = SLOT_W'($urandom_range(0, ENTRY_SLOTS - 1));
    b.source_state = near_state(span);
    b.dest_state   = near_state(span);
    pick = $urandom_range(0, 9);
    b.probability  = (pick == 0) ? '0 :
                     (pick == 1) ? 20'd1000000 :
                     (pick == 2) ? PROB_W'($urandom_range(0, 20'hFFFFF)) :
                                   PROB_W'($urandom_range(1, 400000));
    b.random_value = ($urandom_range(0, 9) == 0) ? PROB_W'($urandom_range(0, 20'hFFFFF))
                                                 : PROB_W'($urandom_range(0, 999999));
    b.target_state = near_state(span);
    pick = $urandom_range(0, 99);
    if (pick < 45)      b.command = CMD_STEP;
    else if (pick < 70) b.command = CMD_LOAD;
    else if (pick < 85) b.command = CMD_READ;
    else                b.command = CMD_RESTART;
    return b;
  endfunction

  task automatic queue_beat(in_item_t b);
    command_backlog.push_back(b);
    queued_total++;
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // Write both registers on back-to-back edges, holding the enable high.
  task automatic set_config(logic [CFG_DATA_W-1:0] states_val,
                            logic [CFG_DATA_W-1:0] entries_val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_STATES_IN_USE;
    cfg_data  <= states_val;
    @(posedge clk);
    cfg_index <= REG_ENTRIES_IN_USE;
    cfg_data  <= entries_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_states  = states_val[LIM_W-1:0];
    reg_entries = entries_val;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] states_val,
                           logic [CFG_DATA_W-1:0] entries_val,
                           int span, int count, bit hold);
    wait_idle();
    set_config(states_val, entries_val);
    if (hold) hold_armed = 1'b1;
    repeat (count) queue_beat(shuffle_command(span));
  endtask

  // Driver: advance to the next beat once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        awaited_results.push_back(advance_chain(in_data));
        accepted_total++;
      end
      if (command_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= command_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat, then choose the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      hold_started <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result state %0d count %0d moved %0d", $time,
                   out_data.present_state, out_data.visit_count, out_data.moved);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: expected state %0d count %0d moved %0d, got state %0d count %0d moved %0d",
                     $time, want.present_state, want.visit_count, want.moved,
                     out_data.present_state, out_data.visit_count, out_data.moved);
            mismatches++;
          end
        end
      end
      if (hold_armed && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_stall    <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sparse_markov_chain_stepper] ERROR");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < CHAIN_STATES; s++) visits[s] = '0;
    visits[0]   = COUNT_W'(1);
    cur_state   = '0;
    reg_states  = LIM_W'(STATES_RESET);
    reg_entries = '0;
    send_idle_pct = 18;
    recv_idle_pct = 51;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: no entries walked yet.
    queue_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 63));
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 63));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 0));
    // zero-probability entry, full certainty, probabilities above one million
    queue_beat(make_beat(CMD_LOAD, 0, 0, 1, 0, 0, 0));
    queue_beat(make_beat(CMD_LOAD, 1, 0, 63, 20'd1000000, 0, 0));
    queue_beat(make_beat(CMD_LOAD, 2, 63, 0, 20'hFFFFF, 0, 0));
    queue_beat(make_beat(CMD_LOAD, 3, 63, 5, 1, 0, 0));
    queue_beat(make_beat(CMD_LOAD, SLOT_W'(ENTRY_SLOTS - 1), 63, 63, 500000, 0, 0));
    // fill the rest of the list so any walk length stays on written entries
    for (int i = 4; i < ENTRY_SLOTS - 1; i++) begin
      in_item_t b;
      b = shuffle_command(8);
      b.command = CMD_LOAD;
      b.slot    = SLOT_W'(i);
      queue_beat(b);
    end

    wait_idle();
    set_config(9'd64, 9'd4);
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 0, 0));
    // draws just below and above one million against a sum above one million
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 20'hFFFFF, 0));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 63));
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 20'd999999, 0));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 63));

    // One state in use: the chain sits above the range and destinations
    // outside it are skipped; restarts outside it are dropped.
    wait_idle();
    set_config(9'd1, 9'd4);
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 20'hFFFFF, 0));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 5));
    queue_beat(make_beat(CMD_RESTART, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CMD_STEP, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 63));

    run_phase(9'd64, 9'd16, 8, 140, 1'b0);
    run_phase(9'd8, 9'd32, 8, 140, 1'b0);
    run_phase(9'd0, 9'd8, 3, 60, 1'b0);

    send_idle_pct = 51;
    recv_idle_pct = 18;
    run_phase(9'd127, 9'd64, 16, 140, 1'b0);
    run_phase(9'd4, 9'd24, 6, 120, 1'b0);
    run_phase(9'd32, 9'd256, 32, 70, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(9'd16, 9'd12, 6, 120, 1'b1);
    run_phase(9'd16, 9'd511, 16, 60, 1'b0);
    run_phase(9'd64, 9'd0, 8, 60, 1'b0);
    run_phase(9'd1, 9'd40, 4, 100, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sparse_markov_chain_stepper] OK");
    end else begin
      $display("[sparse_markov_chain_stepper] ERROR");
    end
    $finish;
  end

endmodule
